// ===== sv/pwt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and constants for the primality witness test block.
// ----------------------------------------------------------------------------
package pwt_pkg;

    localparam int NUM_BITS_DEF = 63;
    localparam int VERDICT_W    = 2;
    localparam int FACTOR_THREE = 3;

    localparam logic [VERDICT_W-1:0] VERDICT_PRIME  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_SMALL  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FERMAT = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_ROOT   = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MM_MOD3,
        OP_MM_RED,
        OP_WB_A,
        OP_POW_E,
        OP_POW_U,
        OP_MM_SQP,
        OP_WB_P,
        OP_MM_MULPA,
        OP_E_SHIFT,
        OP_STRIP,
        OP_CHAIN_INIT,
        OP_MM_SQY,
        OP_WB_Y
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mm_done;
        logic mm_zero;
        logic n_lt2;
        logic n_2or3;
        logic n_even;
        logic e_msb;
        logic e_done;
        logic p_one;
        logic u_even;
        logic y_one;
        logic prev_nm1;
        logic chain_last;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/pwt_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwt_mulmod
// Iterative shift-add modular multiplier: a double-and-reduce step for each
// multiplier bit, plus an add-and-reduce step where that bit is set.
// ----------------------------------------------------------------------------
module pwt_mulmod #(
    parameter int W = pwt_pkg::NUM_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    input  wire logic [W-1:0] m,
    output logic      [W-1:0] result,
    output logic              done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          add_reg, add_next;
    logic          done_reg, done_next;

    logic [W:0]    dbl, dbl_red, sum, sum_red, m_ext;
    logic          advance;

    assign m_ext   = {1'b0, m_reg};
    assign dbl     = {r_reg, 1'b0};
    assign dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    assign sum     = {1'b0, r_reg} + {1'b0, x_reg};
    assign sum_red = (sum >= m_ext) ? sum - m_ext : sum;

    always_comb
    begin
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        add_next  = add_reg;
        done_next = 1'b0;
        advance   = 1'b0;
        if (start)
        begin
            r_next    = '0;
            x_next    = x;
            y_next    = y;
            m_next    = m;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
            add_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!add_reg)
            begin
                r_next = dbl_red[W-1:0];
                if (y_reg[W-1])
                    add_next = 1'b1;
                else
                    advance = 1'b1;
            end
            else
            begin
                r_next   = sum_red[W-1:0];
                add_next = 1'b0;
                advance  = 1'b1;
            end
            if (advance)
            begin
                y_next   = {y_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            add_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            add_reg  <= add_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
        y_reg <= y_next;
        m_reg <= m_next;
    end

    assign result = r_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

// ===== sv/pwt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwt_datapath
// Operand registers, exponent and chain bookkeeping, and the shared modular
// multiplier, driven one command per cycle.
// ----------------------------------------------------------------------------
module pwt_datapath #(
    parameter int W = pwt_pkg::NUM_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [W-1:0]       candidate,
    input  wire logic [W-1:0]       witness,
    input  wire pwt_pkg::dp_cmd_t   cmd,
    output pwt_pkg::dp_status_t     status
);

    localparam int TW = $clog2(W + 1);

    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  nm1_reg, nm1_next;
    logic [W-1:0]  u_reg, u_next;
    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  y_reg, y_next;
    logic [TW-1:0] t_reg, t_next;
    logic [TW-1:0] i_reg, i_next;
    logic [TW-1:0] pcnt_reg, pcnt_next;
    logic          prev_reg, prev_next;

    logic          mm_start;
    logic [W-1:0]  mm_x, mm_y, mm_m, mm_result;
    logic          mm_done;

    assign mm_start = cmd.op inside {pwt_pkg::OP_MM_MOD3, pwt_pkg::OP_MM_RED,
                                     pwt_pkg::OP_MM_SQP, pwt_pkg::OP_MM_MULPA,
                                     pwt_pkg::OP_MM_SQY};

    always_comb
    begin
        mm_x = p_reg;
        mm_y = p_reg;
        mm_m = n_reg;
        case (cmd.op)
            pwt_pkg::OP_MM_MOD3:
            begin
                mm_x = W'(1);
                mm_y = n_reg;
                mm_m = W'(pwt_pkg::FACTOR_THREE);
            end
            pwt_pkg::OP_MM_RED:
            begin
                mm_x = W'(1);
                mm_y = a_reg;
            end
            pwt_pkg::OP_MM_MULPA:
            begin
                mm_x = p_reg;
                mm_y = a_reg;
            end
            pwt_pkg::OP_MM_SQY:
            begin
                mm_x = y_reg;
                mm_y = y_reg;
            end
            default:
            begin
                mm_x = p_reg;
                mm_y = p_reg;
            end
        endcase
    end

    pwt_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .x      (mm_x),
        .y      (mm_y),
        .m      (mm_m),
        .result (mm_result),
        .done   (mm_done)
    );

    always_comb
    begin
        n_next    = n_reg;
        a_next    = a_reg;
        nm1_next  = nm1_reg;
        u_next    = u_reg;
        p_next    = p_reg;
        e_next    = e_reg;
        y_next    = y_reg;
        t_next    = t_reg;
        i_next    = i_reg;
        pcnt_next = pcnt_reg;
        prev_next = prev_reg;
        case (cmd.op)
            pwt_pkg::OP_LOAD:
            begin
                n_next   = candidate;
                a_next   = witness;
                nm1_next = candidate - W'(1);
                u_next   = candidate - W'(1);
                t_next   = '0;
            end
            pwt_pkg::OP_WB_A:
                a_next = mm_result;
            pwt_pkg::OP_POW_E:
            begin
                p_next    = W'(1);
                e_next    = nm1_reg;
                pcnt_next = TW'(W);
            end
            pwt_pkg::OP_POW_U:
            begin
                p_next    = W'(1);
                e_next    = u_reg;
                pcnt_next = TW'(W);
            end
            pwt_pkg::OP_WB_P:
                p_next = mm_result;
            pwt_pkg::OP_E_SHIFT:
            begin
                e_next    = {e_reg[W-2:0], 1'b0};
                pcnt_next = pcnt_reg - TW'(1);
            end
            pwt_pkg::OP_STRIP:
            begin
                u_next = {1'b0, u_reg[W-1:1]};
                t_next = t_reg + TW'(1);
            end
            pwt_pkg::OP_CHAIN_INIT:
            begin
                y_next    = p_reg;
                prev_next = 1'b1;
                i_next    = '0;
            end
            pwt_pkg::OP_MM_SQY:
            begin
                prev_next = (y_reg == nm1_reg);
                i_next    = i_reg + TW'(1);
            end
            pwt_pkg::OP_WB_Y:
                y_next = mm_result;
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= '0;
            i_reg    <= '0;
            pcnt_reg <= '0;
            prev_reg <= 1'b0;
        end
        else
        begin
            t_reg    <= t_next;
            i_reg    <= i_next;
            pcnt_reg <= pcnt_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        a_reg   <= a_next;
        nm1_reg <= nm1_next;
        u_reg   <= u_next;
        p_reg   <= p_next;
        e_reg   <= e_next;
        y_reg   <= y_next;
    end

    assign status.mm_done    = mm_done;
    assign status.mm_zero    = (mm_result == '0);
    assign status.n_lt2      = (n_reg < W'(2));
    assign status.n_2or3     = (n_reg == W'(2)) || (n_reg == W'(3));
    assign status.n_even     = ~n_reg[0];
    assign status.e_msb      = e_reg[W-1];
    assign status.e_done     = (pcnt_reg == '0);
    assign status.p_one      = (p_reg == W'(1));
    assign status.u_even     = ~u_reg[0];
    assign status.y_one      = (y_reg == W'(1));
    assign status.prev_nm1   = prev_reg;
    assign status.chain_last = (i_reg == t_reg);

endmodule
`default_nettype wire

// ===== sv/pwt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwt_ctrl
// Sequencer for the primality test: screening, witness reduction, the two
// exponentiations and the squaring chain; also holds the mode register and
// the result register.
// ----------------------------------------------------------------------------
module pwt_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pwt_pkg::VERDICT_W-1:0]        verdict,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            test_mode,
    output pwt_pkg::dp_cmd_t                     cmd,
    input  wire pwt_pkg::dp_status_t             status
);

    typedef enum logic [16:0] {
        S_IDLE       = 17'h00001,
        S_CHECK      = 17'h00002,
        S_MOD3_W     = 17'h00004,
        S_RED_W      = 17'h00008,
        S_POWE       = 17'h00010,
        S_SQ         = 17'h00020,
        S_SQ_W       = 17'h00040,
        S_MUL_CHK    = 17'h00080,
        S_MUL_W      = 17'h00100,
        S_ESH        = 17'h00200,
        S_POW_NEXT   = 17'h00400,
        S_FERMAT     = 17'h00800,
        S_STRIP      = 17'h01000,
        S_CHAIN_INIT = 17'h02000,
        S_CHAIN      = 17'h04000,
        S_CHAIN_W    = 17'h08000,
        S_DONE       = 17'h10000
    } state_t;

    state_t                        state_reg, state_next;
    logic                          mode_reg, mode_next;
    logic                          second_reg, second_next;
    logic [pwt_pkg::VERDICT_W-1:0] res_reg, res_next;
    logic [pwt_pkg::VERDICT_W-1:0] vout_reg, vout_next;
    logic                          ov_reg, ov_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign verdict   = vout_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        second_next = second_reg;
        res_next    = res_reg;
        vout_next   = vout_reg;
        ov_next     = ov_reg;
        cmd.op      = pwt_pkg::OP_NONE;

        if (cfg_valid)
            mode_next = test_mode;
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = pwt_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.n_lt2)
                begin
                    res_next   = pwt_pkg::VERDICT_SMALL;
                    state_next = S_DONE;
                end
                else if (status.n_2or3)
                begin
                    res_next   = pwt_pkg::VERDICT_PRIME;
                    state_next = S_DONE;
                end
                else if (status.n_even)
                begin
                    res_next   = pwt_pkg::VERDICT_SMALL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = pwt_pkg::OP_MM_MOD3;
                    state_next = S_MOD3_W;
                end
            end
            S_MOD3_W:
            begin
                if (status.mm_done)
                begin
                    if (status.mm_zero)
                    begin
                        res_next   = pwt_pkg::VERDICT_SMALL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = pwt_pkg::OP_MM_RED;
                        state_next = S_RED_W;
                    end
                end
            end
            S_RED_W:
            begin
                if (status.mm_done)
                begin
                    cmd.op     = pwt_pkg::OP_WB_A;
                    state_next = S_POWE;
                end
            end
            S_POWE:
            begin
                cmd.op      = pwt_pkg::OP_POW_E;
                second_next = 1'b0;
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = pwt_pkg::OP_MM_SQP;
                state_next = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (status.mm_done)
                begin
                    cmd.op     = pwt_pkg::OP_WB_P;
                    state_next = S_MUL_CHK;
                end
            end
            S_MUL_CHK:
            begin
                if (status.e_msb)
                begin
                    cmd.op     = pwt_pkg::OP_MM_MULPA;
                    state_next = S_MUL_W;
                end
                else
                begin
                    cmd.op     = pwt_pkg::OP_E_SHIFT;
                    state_next = S_POW_NEXT;
                end
            end
            S_MUL_W:
            begin
                if (status.mm_done)
                begin
                    cmd.op     = pwt_pkg::OP_WB_P;
                    state_next = S_ESH;
                end
            end
            S_ESH:
            begin
                cmd.op     = pwt_pkg::OP_E_SHIFT;
                state_next = S_POW_NEXT;
            end
            S_POW_NEXT:
            begin
                if (!status.e_done)
                    state_next = S_SQ;
                else if (second_reg)
                    state_next = S_CHAIN_INIT;
                else
                    state_next = S_FERMAT;
            end
            S_FERMAT:
            begin
                if (!status.p_one)
                begin
                    res_next   = pwt_pkg::VERDICT_FERMAT;
                    state_next = S_DONE;
                end
                else if (!mode_reg)
                begin
                    res_next   = pwt_pkg::VERDICT_PRIME;
                    state_next = S_DONE;
                end
                else
                    state_next = S_STRIP;
            end
            S_STRIP:
            begin
                if (status.u_even)
                    cmd.op = pwt_pkg::OP_STRIP;
                else
                begin
                    cmd.op      = pwt_pkg::OP_POW_U;
                    second_next = 1'b1;
                    state_next  = S_SQ;
                end
            end
            S_CHAIN_INIT:
            begin
                cmd.op     = pwt_pkg::OP_CHAIN_INIT;
                state_next = S_CHAIN;
            end
            S_CHAIN:
            begin
                if (status.y_one)
                begin
                    res_next   = status.prev_nm1 ? pwt_pkg::VERDICT_PRIME
                                                 : pwt_pkg::VERDICT_ROOT;
                    state_next = S_DONE;
                end
                else if (status.chain_last)
                begin
                    res_next   = pwt_pkg::VERDICT_PRIME;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = pwt_pkg::OP_MM_SQY;
                    state_next = S_CHAIN_W;
                end
            end
            S_CHAIN_W:
            begin
                if (status.mm_done)
                begin
                    cmd.op     = pwt_pkg::OP_WB_Y;
                    state_next = S_CHAIN;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    vout_next  = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b1;
            second_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            second_reg <= second_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        vout_reg <= vout_next;
    end

endmodule
`default_nettype wire

// ===== sv/prime_witness_test_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prime_witness_test_top
// One-witness primality test (Fermat or Miller-Rabin) on a candidate and a
// base, giving one verdict per input beat.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  -------  ------------------------  ----------------------------------------
//  in       in_valid / in_ready       candidate, witness   (NUM_BITS each)
//  out      out_valid / out_ready     verdict              (2 bits)
//  cfg      cfg_valid / cfg_ready     test_mode            (1 bit, reset 1)
//
//  One item at a time. Run time is set by the shared shift-add modular
//  multiplier: one exponentiation is NUM_BITS squarings plus one product
//  per set exponent bit. Miller-Rabin adds a second exponentiation and up
//  to t chain squarings. Candidates below 2, 2, 3 and even ones are
//  screened without a product; the multiple-of-3 check costs one product.
//  Reset is asynchronous and active low; test_mode resets to 1.
//  A stalled verdict beat holds in the output register while the next input
//  beat is taken; cfg_ready is always high.
// ----------------------------------------------------------------------------
module prime_witness_test_top #(
    parameter int NUM_BITS = pwt_pkg::NUM_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [NUM_BITS-1:0]       candidate,
    input  wire logic [NUM_BITS-1:0]       witness,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [pwt_pkg::VERDICT_W-1:0]  verdict,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      test_mode
);

    // Command and status between the sequencer and the datapath.
    pwt_pkg::dp_cmd_t    cmd;
    pwt_pkg::dp_status_t status;

    // Sequencer: screening, exponentiation steps, chain walk, verdict beat.
    pwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .test_mode (test_mode),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: operands, exponent and chain state, modular multiplier.
    pwt_datapath #(
        .W (NUM_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (candidate),
        .witness   (witness),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prime_witness_test_top. It computes every verdict
// from its own model of the Fermat and Miller-Rabin tests. It drives
// candidate/witness beats with random gaps and takes verdict beats with
// random stalls. One long receiver hold-off backs the block up. The
// test_mode register is switched between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int NB               = pwt_pkg::NUM_BITS_DEF;
    localparam int VW               = pwt_pkg::VERDICT_W;
    localparam logic MODE_FERMAT    = 1'b0;
    localparam logic MODE_STRONG    = 1'b1;
    localparam int RESET_CYCLES     = 6;
    localparam int MAX_GAP          = 8;
    // Long enough for two fast screened beats to fill the block and stall it.
    localparam int HOLD_CYCLES      = 1500;
    // Worst item: two full exponentiations plus a full squaring chain.
    // Allow several times that with no beat anywhere.
    localparam int QUIET_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 200;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_PHASES    = 4;
    localparam int RANDOM_PER_PHASE = 17;
    localparam int KNOWN_COUNT      = 20;

    localparam logic [NB-1:0] ALL_ONES = {NB{1'b1}};
    // Largest prime below 2^63.
    localparam logic [NB-1:0] TOP_PRIME = 63'd9223372036854775783;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [NB-1:0]        candidate = '0;
    logic [NB-1:0]        witness   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [VW-1:0]        verdict;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 test_mode = MODE_STRONG;

    typedef struct {
        logic [NB-1:0]        n;
        logic [NB-1:0]        a;
        logic [VW-1:0]        verdict;
    } verdict_entry_t;

    // Verdicts owed by the block, oldest first.
    verdict_entry_t pending_verdicts[$];

    // Bench copy of test_mode; it follows every accepted cfg beat.
    logic active_mode   = MODE_STRONG;
    int   max_gap       = MAX_GAP;
    logic sink_hold     = 1'b0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;

    prime_witness_test_top #(
        .NUM_BITS (NB)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .candidate (candidate),
        .witness   (witness),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .test_mode (test_mode)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Verdict model
    // ------------------------------------------------------------------

    // x*y mod m, MSB first with conditional subtraction, as the block does.
    function automatic logic [63:0] mod_product(input logic [63:0] x,
                                                input logic [63:0] y,
                                                input logic [63:0] m);
        logic [63:0] r;
        int          i;
        r = '0;
        for (i = NB - 1; i >= 0; i--)
        begin
            r = r << 1;
            if (r >= m)
                r = r - m;
            if (y[i])
            begin
                r = r + x;
                if (r >= m)
                    r = r - m;
            end
        end
        return r;
    endfunction

    // base^e mod m by square-and-multiply over all NB exponent bits.
    function automatic logic [63:0] mod_power(input logic [63:0] base,
                                              input logic [63:0] e,
                                              input logic [63:0] m);
        logic [63:0] r;
        int          i;
        r = 64'd1;
        for (i = NB - 1; i >= 0; i--)
        begin
            r = mod_product(r, r, m);
            if (e[i])
                r = mod_product(r, base, m);
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] predict_verdict(input logic [NB-1:0] n,
                                                      input logic [NB-1:0] a,
                                                      input logic mode);
        logic [63:0] nn;
        logic [63:0] aa;
        logic [63:0] nm1;
        logic [63:0] u;
        logic [63:0] y;
        logic [63:0] prev;
        int          t;
        int          i;
        nn = {1'b0, n};
        aa = {1'b0, a};
        if (nn < 64'd2)
            return pwt_pkg::VERDICT_SMALL;
        if (nn == 64'd2 || nn == 64'd3)
            return pwt_pkg::VERDICT_PRIME;
        if (nn[0] == 1'b0 || (nn % pwt_pkg::FACTOR_THREE) == 64'd0)
            return pwt_pkg::VERDICT_SMALL;
        aa  = aa % nn;
        nm1 = nn - 64'd1;
        if (mod_power(aa, nm1, nn) != 64'd1)
            return pwt_pkg::VERDICT_FERMAT;
        if (mode == MODE_FERMAT)
            return pwt_pkg::VERDICT_PRIME;
        // Split n-1 into 2^t * u with u odd, then walk the squaring chain.
        u = nm1;
        t = 0;
        while (u[0] == 1'b0)
        begin
            u = u >> 1;
            t++;
        end
        y    = mod_power(aa, u, nn);
        prev = nm1;
        for (i = 0; i <= t; i++)
        begin
            if (y == 64'd1)
                return (prev != nm1) ? pwt_pkg::VERDICT_ROOT : pwt_pkg::VERDICT_PRIME;
            prev = y;
            y    = mod_product(y, y, nn);
        end
        return pwt_pkg::VERDICT_PRIME;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [NB-1:0] draw_wide();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[NB-1:0];
    endfunction

    // Primes (first half) and Fermat or strong pseudoprimes (second half),
    // none of them divisible by 2 or 3.
    function automatic logic [NB-1:0] known_candidate(input int idx);
        case (idx)
            0:       return 63'd5;
            1:       return 63'd7;
            2:       return 63'd11;
            3:       return 63'd101;
            4:       return 63'd65537;
            5:       return 63'd998244353;
            6:       return 63'd1000000007;
            7:       return 63'd4294967291;
            8:       return 63'd2305843009213693951;
            9:       return TOP_PRIME;
            10:      return 63'd25;
            11:      return 63'd1105;
            12:      return 63'd1729;
            13:      return 63'd2047;
            14:      return 63'd2465;
            15:      return 63'd2821;
            16:      return 63'd3277;
            17:      return 63'd4033;
            18:      return 63'd6601;
            default: return 63'd8911;
        endcase
    endfunction

    // Odd candidate, not a multiple of 3, at least 5: it runs the full test.
    function automatic logic [NB-1:0] draw_deep_candidate();
        logic [NB-1:0] n;
        if ($urandom_range(0, 1) == 0)
            n = known_candidate($urandom_range(0, KNOWN_COUNT - 1));
        else
        begin
            n    = draw_wide() >> $urandom_range(0, NB - 4);
            n[0] = 1'b1;
            if ((n % pwt_pkg::FACTOR_THREE) == 0)
                n = n - 2;
            if (n < 5)
                n = 5;
        end
        return n;
    endfunction

    // Witness in 2..n-2; needs n >= 5.
    function automatic logic [NB-1:0] in_range_witness(input logic [NB-1:0] n);
        return 2 + (draw_wide() % (n - 3));
    endfunction

    // ------------------------------------------------------------------
    // Sender, drain and register write
    // ------------------------------------------------------------------

    // Offer one candidate/witness beat after a random gap; log its verdict
    // at the edge that takes it.
    task automatic send_pair(input logic [NB-1:0] n, input logic [NB-1:0] a);
        int             gap;
        verdict_entry_t entry;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= n;
        witness   <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        entry.n       = n;
        entry.a       = a;
        entry.verdict = predict_verdict(n, a, active_mode);
        pending_verdicts.push_back(entry);
    endtask

    // Drop valid and wait until every owed verdict has come back.
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Write test_mode while the block is idle.
    task automatic write_mode(input logic m);
        drain_verdicts();
        cfg_valid <= 1'b1;
        test_mode <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        active_mode = m;
    endtask

    // ------------------------------------------------------------------
    // Verdict checking
    // ------------------------------------------------------------------

    task automatic score_verdict(input logic [VW-1:0] got);
        verdict_entry_t entry;
        if (pending_verdicts.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected verdict beat: got %0d", got);
        end
        else
        begin
            entry = pending_verdicts.pop_front();
            if (got !== entry.verdict)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("verdict mismatch: candidate %0d witness %0d expected %0d got %0d",
                             entry.n, entry.a, entry.verdict, got);
            end
        end
    endtask

    // Take verdict beats with a random stall before each one. On request,
    // hold ready low for a long, counted stretch so the block backs up.
    initial
    begin : verdict_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (sink_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            else
            begin
                stall = $urandom_range(0, max_gap);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid && !sink_hold)
                @(posedge clk);
            if (out_valid)
                score_verdict(verdict);
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Screening at the reset mode: below 2, the primes 2 and 3, even
    // numbers and multiples of 3, with witness extremes.
    task automatic test_screening();
        send_pair(63'd0, 63'd0);
        send_pair(63'd1, ALL_ONES);
        send_pair(63'd2, 63'd0);
        send_pair(63'd3, ALL_ONES);
        send_pair(63'd4, 63'd3);
        send_pair(63'd9, 63'd2);
        send_pair(ALL_ONES - 1, ALL_ONES);
        send_pair(63'd6, 63'd5);
    endtask

    // Full tests: witness 1 and n-1, a witness above n that reduces to 1,
    // a strong liar, a Carmichael number, a base-2 strong pseudoprime,
    // a witness congruent to 0, and the largest prime.
    task automatic run_deep_set();
        send_pair(63'd5, 63'd3);
        send_pair(63'd13, 63'd1);
        send_pair(63'd13, 63'd12);
        send_pair(63'd13, 63'd40);
        send_pair(63'd25, 63'd7);
        send_pair(63'd1105, 63'd2);
        send_pair(63'd2047, 63'd2);
        send_pair(ALL_ONES, ALL_ONES);
        send_pair(TOP_PRIME, in_range_witness(TOP_PRIME));
    endtask

    task automatic test_fermat_mode();
        write_mode(MODE_FERMAT);
        run_deep_set();
    endtask

    task automatic test_strong_mode();
        write_mode(MODE_STRONG);
        run_deep_set();
    endtask

    // Hold the receiver off while fast screened beats keep coming: the
    // output register fills, the next beat finishes behind it, and
    // in_ready has to drop.
    task automatic test_backpressure();
        drain_verdicts();
        @(negedge clk);
        sink_hold = 1'b1;
        @(posedge clk);
        send_pair(63'd0, draw_wide());
        send_pair(63'd4, draw_wide());
        send_pair(63'd9, draw_wide());
        send_pair(63'd2, draw_wide());
        send_pair(63'd1, draw_wide());
        send_pair(63'd13, 63'd12);
        drain_verdicts();
    endtask

    // Mostly well-formed full tests with random content; the rest are
    // witnesses out of range, screened candidates and raw noise.
    task automatic send_random_item();
        logic [NB-1:0] n;
        logic [NB-1:0] a;
        int            kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            n = draw_deep_candidate();
            a = ($urandom_range(0, 3) == 0) ? 63'd2 : in_range_witness(n);
        end
        else if (kind == 6)
        begin
            n = draw_deep_candidate();
            case ($urandom_range(0, 5))
                0:       a = '0;
                1:       a = 63'd1;
                2:       a = n - 1;
                3:       a = n;
                4:       a = n + 1;
                default: a = draw_wide();
            endcase
        end
        else if (kind == 7)
        begin
            case ($urandom_range(0, 2))
                0:       n = $urandom_range(0, 3);
                1:
                begin
                    n    = draw_wide();
                    n[0] = 1'b0;
                end
                default: n = (draw_wide() >> 2) * 3;
            endcase
            a = draw_wide();
        end
        else
        begin
            n = draw_wide() >> $urandom_range(0, NB - 1);
            a = draw_wide();
        end
        send_pair(n, a);
    endtask

    // Alternate the mode per phase; run one phase with no idling at all.
    task automatic test_random();
        int phase;
        int k;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_mode(phase[0] ? MODE_FERMAT : MODE_STRONG);
            max_gap = (phase == 2) ? 0 : MAX_GAP;
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                send_random_item();
        end
        max_gap = MAX_GAP;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_screening();
        test_fermat_mode();
        test_strong_mode();
        test_backpressure();
        test_random();
        // Drain, then leave room for any stray extra verdict beat.
        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
